@@ rtl/rgbnv_pkg.sv @@
package rgbnv_pkg;

  // Frame bounds; register widths follow from them
  localparam int MAX_WIDTH  = 8192;
  localparam int MAX_HEIGHT = 4096;

  localparam int STRIDE_W = $clog2(MAX_WIDTH) + 1;
  localparam int HEIGHT_W = $clog2(MAX_HEIGHT) + 1;

  // Field widths
  localparam int PIX_W   = 24;
  localparam int COL_W   = 12;
  localparam int ROW_W   = 11;
  localparam int BYTE_W  = 8;
  localparam int LADDR_W = 25;
  localparam int CADDR_W = 26;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = STRIDE_W;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_STRIDE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [STRIDE_W-1:0] LINE_STRIDE_RESET  = 14'd1920;
  localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

  // BT.601 coefficients
  localparam logic [15:0] Y_R = 16'd66;
  localparam logic [15:0] Y_G = 16'd129;
  localparam logic [15:0] Y_B = 16'd25;
  localparam logic [15:0] U_R = 16'd38;
  localparam logic [15:0] U_G = 16'd74;
  localparam logic [15:0] U_B = 16'd112;
  localparam logic [15:0] V_R = 16'd112;
  localparam logic [15:0] V_G = 16'd94;
  localparam logic [15:0] V_B = 16'd18;

  localparam logic [15:0] ROUND_BIAS  = 16'd128;
  localparam logic [16:0] CHROMA_BIAS = 17'd32896;
  localparam logic [7:0]  LUMA_OFFSET = 8'd16;

endpackage

@@ rtl/rgbnv_if.sv @@
interface rgbnv_block_if import rgbnv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_top_left;
  logic [PIX_W-1:0] pixel_top_right;
  logic [PIX_W-1:0] pixel_bottom_left;
  logic [PIX_W-1:0] pixel_bottom_right;
  logic [COL_W-1:0] block_col;
  logic [ROW_W-1:0] block_row;

  modport source (
    output valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
           pixel_bottom_right, block_col, block_row,
    input  ready
  );
  modport sink (
    input  valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
           pixel_bottom_right, block_col, block_row,
    output ready
  );
endinterface

interface rgbnv_result_if import rgbnv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  luma_top_left;
  logic [BYTE_W-1:0]  luma_top_right;
  logic [BYTE_W-1:0]  luma_bottom_left;
  logic [BYTE_W-1:0]  luma_bottom_right;
  logic [BYTE_W-1:0]  chroma_u;
  logic [BYTE_W-1:0]  chroma_v;
  logic [LADDR_W-1:0] luma_addr;
  logic [CADDR_W-1:0] chroma_addr;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_u, chroma_v, luma_addr, chroma_addr,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_u, chroma_v, luma_addr, chroma_addr,
    output ready
  );
endinterface

@@ rtl/rgb_to_nv12_block_converter_top.sv @@
// RGB to NV12 2x2 block converter, BT.601 studio range.
// blocks: one transaction carries a 2x2 block of packed pixels (blue in
// bits 7:0, green 15:8, red 23:16) plus the block column and row.
// results: one transaction per block with four luma bytes, U and V taken
// from the bottom-right pixel, the luma byte address of the top-left pixel
// and the interleaved chroma byte address (V at chroma_addr + 1).
// cfg_we/cfg_index/cfg_data write line_stride (index 0) and frame_height
// (index 1); write only while no block is in flight.
// Results pass through three register stages (products, sums, output
// register), the first loaded at acceptance; results.valid is driven by
// the valid bit of the output register.
// Throughput: one block per clock, sustained while results.ready is high.
// Reset clears all stage valid bits and loads stride 1920, height 1080.
// When the receiver stalls, the output stage holds its result, empty
// stages upstream keep filling, and blocks.ready drops once all three
// stages are full. Nothing is lost or repeated.
module rgb_to_nv12_block_converter_top
  import rgbnv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rgbnv_block_if.sink            blocks,
  rgbnv_result_if.source         results
);

  // Configuration registers
  logic [STRIDE_W-1:0] line_stride;
  logic [HEIGHT_W-1:0] frame_height;

  // Stage valid bits and advance enables
  logic v1, v2, v3;
  logic en1, en2, en3;

  // Stage 1: products
  logic [15:0]        s1_yr [4];
  logic [15:0]        s1_yg [4];
  logic [15:0]        s1_yb [4];
  logic [15:0]        s1_ur, s1_ug, s1_ub;
  logic [15:0]        s1_vr, s1_vg, s1_vb;
  logic [LADDR_W-1:0] s1_row_prod;
  logic [CADDR_W-1:0] s1_chroma_prod;
  logic [COL_W-1:0]   s1_col;

  // Stage 2: sums
  logic [15:0]        s2_ysum [4];
  logic [16:0]        s2_usum, s2_vsum;
  logic [LADDR_W-1:0] s2_luma_addr;
  logic [CADDR_W-1:0] s2_chroma_addr;

  // Stage 3: output register
  logic [BYTE_W-1:0]  s3_luma [4];
  logic [BYTE_W-1:0]  s3_u, s3_v;
  logic [LADDR_W-1:0] s3_luma_addr;
  logic [CADDR_W-1:0] s3_chroma_addr;

  // Stage 1 combinational inputs
  logic [PIX_W-1:0]    px [4];
  logic [15:0]         yr_next [4];
  logic [15:0]         yg_next [4];
  logic [15:0]         yb_next [4];
  logic [STRIDE_W-1:0] hr_sum;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_stride  <= LINE_STRIDE_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_STRIDE:  line_stride  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the next one moves
  assign en3 = !v3 || results.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign blocks.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= blocks.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Split pixels and form luma products
  always_comb begin
    px[0] = blocks.pixel_top_left;
    px[1] = blocks.pixel_top_right;
    px[2] = blocks.pixel_bottom_left;
    px[3] = blocks.pixel_bottom_right;
    for (int i = 0; i < 4; i++) begin
      yr_next[i] = 16'(px[i][23:16]) * Y_R;
      yg_next[i] = 16'(px[i][15:8])  * Y_G;
      yb_next[i] = 16'(px[i][7:0])   * Y_B;
    end
    hr_sum = STRIDE_W'(frame_height) + STRIDE_W'(blocks.block_row);
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 4; i++) begin
        s1_yr[i] <= yr_next[i];
        s1_yg[i] <= yg_next[i];
        s1_yb[i] <= yb_next[i];
      end
      s1_ur <= 16'(blocks.pixel_bottom_right[23:16]) * U_R;
      s1_ug <= 16'(blocks.pixel_bottom_right[15:8])  * U_G;
      s1_ub <= 16'(blocks.pixel_bottom_right[7:0])   * U_B;
      s1_vr <= 16'(blocks.pixel_bottom_right[23:16]) * V_R;
      s1_vg <= 16'(blocks.pixel_bottom_right[15:8])  * V_G;
      s1_vb <= 16'(blocks.pixel_bottom_right[7:0])   * V_B;
      s1_row_prod    <= LADDR_W'(blocks.block_row) * LADDR_W'(line_stride);
      s1_chroma_prod <= CADDR_W'(hr_sum) * CADDR_W'(line_stride);
      s1_col         <= blocks.block_col;
    end
  end

  // Stage 2: sum terms, add column offset
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 4; i++) begin
        s2_ysum[i] <= s1_yr[i] + s1_yg[i] + s1_yb[i] + ROUND_BIAS;
      end
      s2_usum <= 17'(s1_ub) + CHROMA_BIAS - 17'(s1_ur) - 17'(s1_ug);
      s2_vsum <= 17'(s1_vr) + CHROMA_BIAS - 17'(s1_vg) - 17'(s1_vb);
      s2_luma_addr   <= {s1_row_prod[LADDR_W-2:0], 1'b0} + LADDR_W'({s1_col, 1'b0});
      s2_chroma_addr <= s1_chroma_prod + CADDR_W'({s1_col, 1'b0});
    end
  end

  // Stage 3: scale and offset
  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 4; i++) begin
        s3_luma[i] <= s2_ysum[i][15:8] + LUMA_OFFSET;
      end
      s3_u           <= s2_usum[15:8];
      s3_v           <= s2_vsum[15:8];
      s3_luma_addr   <= s2_luma_addr;
      s3_chroma_addr <= s2_chroma_addr;
    end
  end

  assign results.valid             = v3;
  assign results.luma_top_left     = s3_luma[0];
  assign results.luma_top_right    = s3_luma[1];
  assign results.luma_bottom_left  = s3_luma[2];
  assign results.luma_bottom_right = s3_luma[3];
  assign results.chroma_u          = s3_u;
  assign results.chroma_v          = s3_v;
  assign results.luma_addr         = s3_luma_addr;
  assign results.chroma_addr       = s3_chroma_addr;

`ifndef SYNTH
  // An empty output stage never blocks the input
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !v3 |-> blocks.ready)
    else $error("input stalled with empty output stage");

  // An accepted transaction occupies stage 1 next cycle
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (blocks.valid && blocks.ready) |=> v1)
    else $error("accepted transaction dropped at stage 1");

  // A full stage 2 with a moving output reaches the output
  a_s2_moves_out: assert property (@(posedge clk) disable iff (rst)
    (v2 && en3) |=> results.valid)
    else $error("stage 2 transaction lost");

  // Top-left luma stays in studio range
  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.luma_top_left >= 8'd16 && results.luma_top_left <= 8'd235))
    else $error("luma out of range");

  // Luma address is even
  a_luma_addr_even: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !results.luma_addr[0])
    else $error("odd luma address");
`endif

endmodule
